// File: hw/rtl/tcphm_pkg.sv
// shared constants and types for the tcp header match filter
package tcphm_pkg;

	localparam int unsigned POS_W = 6;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [POS_W-1:0] PROTOCOL_OFFSET = 6'd23;
	localparam logic [POS_W-1:0] SRC_ADDR_FIRST = 6'd26;
	localparam logic [POS_W-1:0] SRC_ADDR_LAST = 6'd29;
	localparam logic [POS_W-1:0] DST_ADDR_FIRST = 6'd30;
	localparam logic [POS_W-1:0] DST_ADDR_LAST = 6'd33;
	localparam logic [POS_W-1:0] SRC_PORT_FIRST = 6'd34;
	localparam logic [POS_W-1:0] SRC_PORT_LAST = 6'd35;
	localparam logic [POS_W-1:0] DST_PORT_FIRST = 6'd36;
	localparam logic [POS_W-1:0] DST_PORT_LAST = 6'd37;
	localparam logic [POS_W-1:0] HEADER_END = 6'd38;

	localparam logic [7:0] PROTOCOL_TCP = 8'd6;

	// 172.24.128.50
	localparam logic [31:0] SRC_ADDR_RESET = 32'hAC18_8032;
	localparam logic [15:0] DST_PORT_RESET = 16'd4242;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SRC_ADDR     = 3'd0,
		CFG_SRC_ADDR_EN  = 3'd1,
		CFG_DST_ADDR     = 3'd2,
		CFG_DST_ADDR_EN  = 3'd3,
		CFG_SRC_PORT     = 3'd4,
		CFG_DST_PORT     = 3'd5
	} cfg_index_t;

endpackage

// File: hw/rtl/tcp_header_match_filter.sv
// tcp header match filter top level
//
// ethernet frames enter one byte per request on the s_axis channel, tdata carries
// the byte and tlast marks the final byte of a frame. the block assumes a 14-byte
// ethernet header and a fixed 20-byte ipv4 header, picks up the protocol byte,
// both addresses and both tcp ports, and on the final byte sends one result request
// on m_axis: tuser is the match flag, tdata the wrapping count of tcp frames seen
// (including this one). bytes that are not last produce no result.
// a frame matches when it is tcp, at least 38 bytes long and passes every enabled
// address rule and every nonzero port rule.
// the user writes rules over the cfg channel (index, data) only while the block
// is idle; the block does not enforce it. cfg_ready is always high.
// a last byte's request goes into the input register, then its result into the
// result register. one byte per cycle is taken while the result register is free
// for each last byte, set by the single input stage feeding the result register.
// when the receiver stalls, the result waits in the output register; the input
// stage still takes non-last bytes and one more last byte, then holds tready low
// until the result is taken.
// reset clears the frame state and the counter and loads the rule defaults
// (source 172.24.128.50 checked, destination port 4242).
module tcp_header_match_filter (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
	input  logic        s_axis_tlast,   // frame_last

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] tcp_frames_seen
	output logic        m_axis_tuser,   // [0] frame_matched

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tcphm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tcphm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// rule registers
	logic [31:0] src_addr_rule_q;
	logic        src_addr_en_q;
	logic [31:0] dst_addr_rule_q;
	logic        dst_addr_en_q;
	logic [15:0] src_port_rule_q;
	logic [15:0] dst_port_rule_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// frame state
	logic [tcphm_pkg::POS_W-1:0] byte_pos_q;
	logic        tcp_q;
	logic [31:0] src_addr_q;
	logic [31:0] dst_addr_q;
	logic [15:0] src_port_q;
	logic [15:0] dst_port_q;
	logic [31:0] tcp_count_q;

	// result register
	logic        out_valid_q;
	logic        out_match_q;
	logic [31:0] out_count_q;

	// next frame state for the byte in the input stage
	logic [tcphm_pkg::POS_W-1:0] pos_n;
	logic        tcp_n;
	logic [31:0] src_addr_n;
	logic [31:0] dst_addr_n;
	logic [15:0] src_port_n;
	logic [15:0] dst_port_n;
	logic [31:0] count_n;
	logic        match_n;

	logic        out_free;
	logic        s1_go;
	logic        in_take;

	assign cfg_ready = 1'b1;

	// config writes, unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_addr_rule_q <= tcphm_pkg::SRC_ADDR_RESET;
			src_addr_en_q   <= 1'b1;
			dst_addr_rule_q <= '0;
			dst_addr_en_q   <= 1'b0;
			src_port_rule_q <= '0;
			dst_port_rule_q <= tcphm_pkg::DST_PORT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				tcphm_pkg::CFG_SRC_ADDR:    src_addr_rule_q <= cfg_data[31:0];
				tcphm_pkg::CFG_SRC_ADDR_EN: src_addr_en_q   <= cfg_data[0];
				tcphm_pkg::CFG_DST_ADDR:    dst_addr_rule_q <= cfg_data[31:0];
				tcphm_pkg::CFG_DST_ADDR_EN: dst_addr_en_q   <= cfg_data[0];
				tcphm_pkg::CFG_SRC_PORT:    src_port_rule_q <= cfg_data[15:0];
				tcphm_pkg::CFG_DST_PORT:    dst_port_rule_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// flow control: a non-last byte never needs the result register
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_go         = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || s1_go;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// header field capture
	always_comb begin
		tcp_n      = tcp_q;
		src_addr_n = src_addr_q;
		dst_addr_n = dst_addr_q;
		src_port_n = src_port_q;
		dst_port_n = dst_port_q;
		if (byte_pos_q == tcphm_pkg::PROTOCOL_OFFSET) begin
			tcp_n = (byte_s1 == tcphm_pkg::PROTOCOL_TCP);
		end else if (byte_pos_q >= tcphm_pkg::SRC_ADDR_FIRST &&
		             byte_pos_q <= tcphm_pkg::SRC_ADDR_LAST) begin
			src_addr_n = {src_addr_q[23:0], byte_s1};
		end else if (byte_pos_q >= tcphm_pkg::DST_ADDR_FIRST &&
		             byte_pos_q <= tcphm_pkg::DST_ADDR_LAST) begin
			dst_addr_n = {dst_addr_q[23:0], byte_s1};
		end else if (byte_pos_q >= tcphm_pkg::SRC_PORT_FIRST &&
		             byte_pos_q <= tcphm_pkg::SRC_PORT_LAST) begin
			src_port_n = {src_port_q[7:0], byte_s1};
		end else if (byte_pos_q >= tcphm_pkg::DST_PORT_FIRST &&
		             byte_pos_q <= tcphm_pkg::DST_PORT_LAST) begin
			dst_port_n = {dst_port_q[7:0], byte_s1};
		end

		// position saturates at the end of the tcp ports
		if (byte_pos_q < tcphm_pkg::HEADER_END) begin
			pos_n = byte_pos_q + 1'b1;
		end else begin
			pos_n = byte_pos_q;
		end

		count_n = tcp_n ? tcp_count_q + 32'd1 : tcp_count_q;

		match_n = tcp_n && (pos_n >= tcphm_pkg::HEADER_END);
		if (src_addr_en_q && src_addr_n != src_addr_rule_q) begin
			match_n = 1'b0;
		end
		if (dst_addr_en_q && dst_addr_n != dst_addr_rule_q) begin
			match_n = 1'b0;
		end
		if (src_port_rule_q != 16'd0 && src_port_n != src_port_rule_q) begin
			match_n = 1'b0;
		end
		if (dst_port_rule_q != 16'd0 && dst_port_n != dst_port_rule_q) begin
			match_n = 1'b0;
		end
	end

	// frame state update, position and protocol flag restart after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q  <= '0;
			tcp_q       <= 1'b0;
			src_addr_q  <= '0;
			dst_addr_q  <= '0;
			src_port_q  <= '0;
			dst_port_q  <= '0;
			tcp_count_q <= '0;
		end else if (s1_go) begin
			src_addr_q <= src_addr_n;
			dst_addr_q <= dst_addr_n;
			src_port_q <= src_port_n;
			dst_port_q <= dst_port_n;
			if (last_s1) begin
				byte_pos_q  <= '0;
				tcp_q       <= 1'b0;
				tcp_count_q <= count_n;
			end else begin
				byte_pos_q <= pos_n;
				tcp_q      <= tcp_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			out_match_q <= match_n;
			out_count_q <= count_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_match_q;
	assign m_axis_tdata  = out_count_q;

	// a new result only comes from a last byte leaving the input stage
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result appeared without a last byte");

	// position never runs past the saturation point
	a_pos_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= tcphm_pkg::HEADER_END)
		else $error("byte position beyond header end");

	// counter only ever steps by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tcp_count_q) |-> tcp_count_q == $past(tcp_count_q) + 32'd1)
		else $error("tcp frame counter jumped");

	// frame state restarts together with a new result
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (byte_pos_q == '0 && !tcp_q))
		else $error("frame state not cleared at frame end");

endmodule

// File: verif/tcp_header_match_filter_checker.sv
`timescale 1ns / 100ps
// checker for the tcp header match filter: predicts each verdict and compares it on arrival
module tcp_header_match_filter_checker
	import tcphm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,   // [7:0] frame_byte
	input  logic                   s_axis_tlast,   // frame_last

	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [31:0]            m_axis_tdata,   // [31:0] tcp_frames_seen
	input  logic                   m_axis_tuser,   // [0] frame_matched

	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,

	output int unsigned            mismatch_count,
	output int unsigned            verdicts_waiting,
	output int unsigned            verdicts_checked,
	output int unsigned            matches_checked
);

	typedef struct packed {
		logic        matched;
		logic [31:0] tcp_count;
	} verdict_t;

	verdict_t pending_verdicts[$];

	// rule copies
	logic [31:0] src_addr_rule, dst_addr_rule;
	logic        src_addr_on, dst_addr_on;
	logic [15:0] src_port_rule, dst_port_rule;

	// per-frame capture
	logic [POS_W-1:0] offset;
	logic             saw_tcp;
	logic [31:0]      src_addr_seen, dst_addr_seen;
	logic [15:0]      src_port_seen, dst_port_seen;
	logic [31:0]      tcp_count;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t ns mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t want;
		verdict_t next;
		if (!arst_n) begin
			src_addr_rule = SRC_ADDR_RESET;
			src_addr_on = 1'b1;
			dst_addr_rule = '0;
			dst_addr_on = 1'b0;
			src_port_rule = '0;
			dst_port_rule = DST_PORT_RESET;
			offset = '0;
			saw_tcp = 1'b0;
			src_addr_seen = '0;
			dst_addr_seen = '0;
			src_port_seen = '0;
			dst_port_seen = '0;
			tcp_count = '0;
			pending_verdicts.delete();
			mismatch_count = 0;
			verdicts_waiting = 0;
			verdicts_checked = 0;
			matches_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SRC_ADDR:    src_addr_rule = cfg_data;
					CFG_SRC_ADDR_EN: src_addr_on = cfg_data[0];
					CFG_DST_ADDR:    dst_addr_rule = cfg_data;
					CFG_DST_ADDR_EN: dst_addr_on = cfg_data[0];
					CFG_SRC_PORT:    src_port_rule = cfg_data[15:0];
					CFG_DST_PORT:    dst_port_rule = cfg_data[15:0];
					default: ;
				endcase
			end

			// results come out only after their last byte is registered, so check first
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_verdicts.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata, '0);
				end else begin
					want = pending_verdicts.pop_front();
					verdicts_checked++;
					if (m_axis_tuser === 1'b1)
						matches_checked++;
					if (m_axis_tuser !== want.matched)
						report_mismatch("frame_matched", 32'(m_axis_tuser), 32'(want.matched));
					if (m_axis_tdata !== want.tcp_count)
						report_mismatch("tcp_frames_seen", m_axis_tdata, want.tcp_count);
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				if (offset == PROTOCOL_OFFSET)
					saw_tcp = (s_axis_tdata == PROTOCOL_TCP);
				else if (offset >= SRC_ADDR_FIRST && offset <= SRC_ADDR_LAST)
					src_addr_seen = {src_addr_seen[23:0], s_axis_tdata};
				else if (offset >= DST_ADDR_FIRST && offset <= DST_ADDR_LAST)
					dst_addr_seen = {dst_addr_seen[23:0], s_axis_tdata};
				else if (offset >= SRC_PORT_FIRST && offset <= SRC_PORT_LAST)
					src_port_seen = {src_port_seen[7:0], s_axis_tdata};
				else if (offset >= DST_PORT_FIRST && offset <= DST_PORT_LAST)
					dst_port_seen = {dst_port_seen[7:0], s_axis_tdata};
				// position sticks once the header is through
				if (offset < HEADER_END)
					offset = offset + 1'b1;

				if (s_axis_tlast) begin
					if (saw_tcp)
						tcp_count = tcp_count + 1;
					next.matched = saw_tcp && (offset >= HEADER_END)
						&& (!src_addr_on || src_addr_seen == src_addr_rule)
						&& (!dst_addr_on || dst_addr_seen == dst_addr_rule)
						&& (src_port_rule == '0 || src_port_seen == src_port_rule)
						&& (dst_port_rule == '0 || dst_port_seen == dst_port_rule);
					next.tcp_count = tcp_count;
					pending_verdicts.push_back(next);
					// captured fields survive into the next frame
					offset = '0;
					saw_tcp = 1'b0;
				end
			end
			verdicts_waiting = pending_verdicts.size();
		end
	end

endmodule

// File: verif/tcp_header_match_filter_tb.sv
`timescale 1ns / 100ps
// testbench top for the tcp header match filter: stimulus, flow control and verdict
module tcp_header_match_filter_tb;
	import tcphm_pkg::*;

	// index values past the last rule register, written to show they do nothing
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

	// stimulus stops once both of these are reached, at a phase boundary
	localparam int unsigned BYTE_TARGET = 1050;
	localparam int unsigned FRAME_TARGET = 24;
	localparam int unsigned FRAMES_PER_PHASE = 4;
	// receiver hold-off long enough to back the block up into its input
	localparam int unsigned LONG_HOLD = 160;
	// limit for the runaway guard, well above the length of the slowest run
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic                   clk;
	logic                   arst_n;

	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata;   // [7:0] frame_byte
	logic                   s_axis_tlast;   // frame_last

	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [31:0]            m_axis_tdata;   // [31:0] tcp_frames_seen
	logic                   m_axis_tuser;   // [0] frame_matched

	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int unsigned mismatch_count;
	int unsigned verdicts_waiting;
	int unsigned verdicts_checked;
	int unsigned matches_checked;

	// shared between the sender and the receiver process
	bit no_gaps;
	bit hold_off_request;

	int unsigned cycle_count;
	int unsigned bytes_sent;
	int unsigned frames_sent;

	// the frame currently being sent, first byte first
	logic [7:0] frame_buf[$];

	// tb copies of the rules, used to aim frames at the filter
	logic [31:0] rule_src_addr, rule_dst_addr;
	logic        rule_src_on, rule_dst_on;
	logic [15:0] rule_src_port, rule_dst_port;

	tcp_header_match_filter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	tcp_header_match_filter_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_axis_tvalid    (s_axis_tvalid),
		.s_axis_tready    (s_axis_tready),
		.s_axis_tdata     (s_axis_tdata),
		.s_axis_tlast     (s_axis_tlast),
		.m_axis_tvalid    (m_axis_tvalid),
		.m_axis_tready    (m_axis_tready),
		.m_axis_tdata     (m_axis_tdata),
		.m_axis_tuser     (m_axis_tuser),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mismatch_count   (mismatch_count),
		.verdicts_waiting (verdicts_waiting),
		.verdicts_checked (verdicts_checked),
		.matches_checked  (matches_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// runaway guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				verdicts_waiting);
			$display("[tcp_header_match_filter] ERROR");
			$finish;
		end
	end

	// send every byte of frame_buf, tlast on the final one; inputs move on the
	// falling edge, handshakes are seen on the rising edge
	task automatic send_frame();
		int unsigned gap;
		for (int k = 0; k < frame_buf.size(); k++) begin
			gap = no_gaps ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			// valid stays high across back-to-back requests
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= frame_buf[k];
			s_axis_tlast <= (k == frame_buf.size() - 1);
			do @(posedge clk); while (!s_axis_tready);
			@(negedge clk);
			bytes_sent++;
		end
		frames_sent++;
	endtask

	// let the block go quiet: no request offered, every result in, then the
	// input and result registers given some slack
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (verdicts_waiting != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// a header field that mostly hits the rule, sometimes misses by one bit,
	// sometimes is anything at all
	function automatic logic [31:0] aim_at(input logic [31:0] rule, input int unsigned bits);
		logic [31:0] mask;
		mask = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1);
		case ($urandom_range(0, 3))
			0: return $urandom() & mask;
			1: return rule ^ (32'd1 << $urandom_range(0, bits - 1));
			default: return rule;
		endcase
	endfunction

	// receiver: holds tready off for a random count after each result, none in
	// gap-free phases, and once for a long stretch so the block backs up
	initial begin : result_sink
		int unsigned stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		m_axis_tready <= 1'b1;
		forever begin
			do @(posedge clk); while (!m_axis_tvalid);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				stall = LONG_HOLD;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(0, 11);
			end
			if (stall > 0) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
				@(negedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int unsigned phase;
		int unsigned len;
		int unsigned sel;
		logic [31:0] hdr_src_addr, hdr_dst_addr;
		logic [15:0] hdr_src_port, hdr_dst_port;
		logic [7:0]  hdr_protocol;
		logic [7:0]  b;

		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SRC_ADDR;
		cfg_data = '0;
		no_gaps = 1'b0;
		hold_off_request = 1'b0;
		cycle_count = 0;
		bytes_sent = 0;
		frames_sent = 0;

		// rule values after reset
		rule_src_addr = SRC_ADDR_RESET;
		rule_src_on = 1'b1;
		rule_dst_addr = '0;
		rule_dst_on = 1'b0;
		rule_src_port = '0;
		rule_dst_port = DST_PORT_RESET;

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// a frame of one byte: ends at once, not tcp, no match
		frame_buf.delete();
		frame_buf.push_back(8'hFF);
		send_frame();

		// short frame that still carries tcp in the protocol byte: counted, never matched
		frame_buf.delete();
		for (int i = 0; i < int'(PROTOCOL_OFFSET); i++)
			frame_buf.push_back(8'h00);
		frame_buf.push_back(PROTOCOL_TCP);
		send_frame();

		phase = 0;
		while (bytes_sent < BYTE_TARGET || frames_sent < FRAME_TARGET) begin
			if (phase > 0) begin
				drain_results();
				case (phase)
					1: begin
						// all-zero source, all-ones destination, widest source port
						rule_src_addr = '0;
						rule_src_on = 1'b1;
						rule_dst_addr = 32'hFFFF_FFFF;
						rule_dst_on = 1'b1;
						rule_src_port = 16'hFFFF;
						rule_dst_port = '0;
					end
					2: begin
						rule_src_addr = 32'hFFFF_FFFF;
						rule_src_on = 1'b0;
						rule_dst_addr = '0;
						rule_dst_on = 1'b1;
						rule_src_port = '0;
						rule_dst_port = 16'hFFFF;
					end
					3: begin
						// everything open: any tcp frame with a full header passes
						rule_src_addr = $urandom();
						rule_src_on = 1'b0;
						rule_dst_addr = $urandom();
						rule_dst_on = 1'b0;
						rule_src_port = '0;
						rule_dst_port = '0;
					end
					default: begin
						rule_src_addr = $urandom();
						rule_src_on = 1'($urandom_range(0, 1));
						rule_dst_addr = $urandom();
						rule_dst_on = 1'($urandom_range(0, 1));
						rule_src_port = ($urandom_range(0, 2) == 0) ? '0 : 16'($urandom_range(1, 65535));
						rule_dst_port = ($urandom_range(0, 2) == 0) ? '0 : 16'($urandom_range(1, 65535));
					end
				endcase
				// junk above each register's width must be dropped
				cfg_write(CFG_SRC_ADDR, rule_src_addr);
				cfg_write(CFG_SRC_ADDR_EN, ($urandom() & 32'hFFFF_FFFE) | 32'(rule_src_on));
				cfg_write(CFG_DST_ADDR, rule_dst_addr);
				cfg_write(CFG_DST_ADDR_EN, ($urandom() & 32'hFFFF_FFFE) | 32'(rule_dst_on));
				cfg_write(CFG_SRC_PORT, ($urandom() & 32'hFFFF_0000) | 32'(rule_src_port));
				cfg_write(CFG_DST_PORT, ($urandom() & 32'hFFFF_0000) | 32'(rule_dst_port));
				// writes past the register file must leave the rules alone
				cfg_write(CFG_SPARE_LO, $urandom());
				cfg_write(CFG_SPARE_HI, $urandom());
				cfg_valid <= 1'b0;
			end

			// every third phase runs flat out on both sides, but for phase 2's long hold-off
			no_gaps = (phase % 3 == 2);
			if (phase == 2)
				hold_off_request = 1'b1;

			repeat (FRAMES_PER_PHASE) begin
				// mostly full headers, some cut short, a few running long
				sel = $urandom_range(0, 19);
				if (sel < 3)
					len = $urandom_range(1, int'(HEADER_END) - 1);
				else if (sel == 3)
					len = $urandom_range(int'(HEADER_END) + 1, 63);
				else
					len = $urandom_range(int'(HEADER_END), int'(HEADER_END) + 4);
				hdr_protocol = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : PROTOCOL_TCP;
				hdr_src_addr = aim_at(rule_src_addr, 32);
				hdr_dst_addr = aim_at(rule_dst_addr, 32);
				hdr_src_port = 16'(aim_at(32'(rule_src_port), 16));
				hdr_dst_port = 16'(aim_at(32'(rule_dst_port), 16));

				frame_buf.delete();
				for (int i = 0; i < len; i++) begin
					b = 8'($urandom());
					if (i == int'(PROTOCOL_OFFSET))
						b = hdr_protocol;
					else if (i >= int'(SRC_ADDR_FIRST) && i <= int'(SRC_ADDR_LAST))
						b = 8'(hdr_src_addr >> (8 * (int'(SRC_ADDR_LAST) - i)));
					else if (i >= int'(DST_ADDR_FIRST) && i <= int'(DST_ADDR_LAST))
						b = 8'(hdr_dst_addr >> (8 * (int'(DST_ADDR_LAST) - i)));
					else if (i >= int'(SRC_PORT_FIRST) && i <= int'(SRC_PORT_LAST))
						b = 8'(hdr_src_port >> (8 * (int'(SRC_PORT_LAST) - i)));
					else if (i >= int'(DST_PORT_FIRST) && i <= int'(DST_PORT_LAST))
						b = 8'(hdr_dst_port >> (8 * (int'(DST_PORT_LAST) - i)));
					frame_buf.push_back(b);
				end
				send_frame();
			end
			phase++;
		end

		drain_results();
		$display("sent %0d frames (%0d bytes) across %0d rule settings", frames_sent,
			bytes_sent, phase);
		$display("checked %0d results, %0d of them matches", verdicts_checked,
			matches_checked);
		if (mismatch_count == 0)
			$display("[tcp_header_match_filter] OK");
		else
			$display("[tcp_header_match_filter] ERROR");
		$finish;
	end

endmodule
